// File: rtl/sst_pkg.sv
package sst_pkg;

	// Defaults and fixed field widths
	localparam int DEF_NUM_SLOTS = 64;
	localparam int SEQ_W         = 32;
	localparam int SLOT_W        = 6;
	localparam int MAXS_W        = 7;
	localparam int CNT_W         = 7;

	// Slots held by one cell of the chain
	localparam int CELL_SLOTS = 8;
	localparam int CELL_LW    = $clog2(CELL_SLOTS);

	localparam logic [MAXS_W-1:0] MAXS_RST = 7'd64;
	localparam logic [SEQ_W-1:0]  SEQ_INIT = 32'd1;

	// Result status codes
	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef enum logic [1:0] {
		CMD_GET   = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_BUMP  = 2'd2,
		CMD_CLEAR = 2'd3
	} cmd_t;

	// Control flags carried by the wave as it steps along the cells
	typedef struct packed {
		logic valid;
		cmd_t cmd;
		logic get_ok;    // count below limit when the item entered
		logic sid_ok;    // slot_id names an existing slot
		logic found;     // a free slot has been granted
		logic was_used;  // freed slot was in use
		logic high_hit;  // a used slot at or below the highest mark seen
	} wave_t;

endpackage

// File: rtl/sst_cell.sv
module sst_cell #(
	parameter int NUM_SLOTS = sst_pkg::DEF_NUM_SLOTS,
	parameter int CELL_IDX  = 0,
	localparam int IDX_W = $clog2(((NUM_SLOTS + sst_pkg::CELL_SLOTS - 1) /
		sst_pkg::CELL_SLOTS) * sst_pkg::CELL_SLOTS)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  sst_pkg::wave_t           prv_wave,
	input  logic [IDX_W-1:0]         prv_sid,
	input  logic [IDX_W-1:0]         prv_idx,
	input  logic [IDX_W-1:0]         prv_high,
	input  logic [sst_pkg::SEQ_W-1:0] prv_seq,
	input  logic [IDX_W:0]           limit,
	input  logic [IDX_W-1:0]         hmark,
	output sst_pkg::wave_t           nxt_wave,
	output logic [IDX_W-1:0]         nxt_sid,
	output logic [IDX_W-1:0]         nxt_idx,
	output logic [IDX_W-1:0]         nxt_high,
	output logic [sst_pkg::SEQ_W-1:0] nxt_seq
);
	import sst_pkg::*;

	localparam int LIM_W = IDX_W + 1;
	localparam logic [IDX_W-1:0] BASE    = IDX_W'(CELL_IDX * CELL_SLOTS);
	localparam logic [IDX_W-1:0] CELL_NO = IDX_W'(CELL_IDX);

	logic [CELL_SLOTS-1:0] used_q, used_d;
	logic [SEQ_W-1:0]      seq_q [CELL_SLOTS];
	logic [SEQ_W-1:0]      seq_d [CELL_SLOTS];
	logic [CELL_SLOTS-1:0] free_m;
	logic [CELL_LW-1:0]    loc, pick;
	logic                  mine, hit;

	wave_t            wave_d, wave_q;
	logic [IDX_W-1:0] idx_d, high_d;
	logic [SEQ_W-1:0] sq_d;
	logic [IDX_W-1:0] sid_q, idx_q, high_q;
	logic [SEQ_W-1:0] sq_q;

	always_comb begin
		used_d = used_q;
		seq_d  = seq_q;
		wave_d = prv_wave;
		idx_d  = prv_idx;
		high_d = prv_high;
		sq_d   = prv_seq;
		loc    = prv_sid[CELL_LW-1:0];
		mine   = prv_wave.sid_ok && ((prv_sid >> CELL_LW) == CELL_NO);
		hit    = 1'b0;
		pick   = '0;

		for (int j = 0; j < CELL_SLOTS; j++) begin
			free_m[j] = !used_q[j] && (LIM_W'(BASE + IDX_W'(j)) < limit);
		end
		// lowest free slot wins
		for (int j = CELL_SLOTS - 1; j >= 0; j--) begin
			if (free_m[j]) begin
				hit  = 1'b1;
				pick = CELL_LW'(j);
			end
		end

		if (prv_wave.valid) begin
			unique case (prv_wave.cmd)
				CMD_GET: begin
					if (prv_wave.get_ok && !prv_wave.found && hit) begin
						used_d[pick] = 1'b1;
						wave_d.found = 1'b1;
						idx_d        = BASE + IDX_W'(pick);
						sq_d         = seq_q[pick];
					end
				end
				CMD_FREE: begin
					if (mine) begin
						wave_d.was_used = used_q[loc];
						used_d[loc]     = 1'b0;
					end
					// ascending, so the last hit is the highest used slot under the mark
					for (int j = 0; j < CELL_SLOTS; j++) begin
						if (used_d[j] && ((BASE + IDX_W'(j)) <= hmark)) begin
							wave_d.high_hit = 1'b1;
							high_d          = BASE + IDX_W'(j);
						end
					end
				end
				CMD_BUMP: begin
					if (mine) begin
						seq_d[loc] = seq_q[loc] + SEQ_W'(1);
					end
				end
				CMD_CLEAR: begin
					used_d = '0;
					for (int j = 0; j < CELL_SLOTS; j++) begin
						seq_d[j] = SEQ_INIT;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			for (int j = 0; j < CELL_SLOTS; j++) begin
				seq_q[j] <= SEQ_INIT;
			end
			wave_q <= '0;
		end else begin
			used_q <= used_d;
			seq_q  <= seq_d;
			wave_q <= wave_d;
		end
	end

	always_ff @(posedge clk) begin
		sid_q  <= prv_sid;
		idx_q  <= idx_d;
		high_q <= high_d;
		sq_q   <= sq_d;
	end

	assign nxt_wave = wave_q;
	assign nxt_sid  = sid_q;
	assign nxt_idx  = idx_q;
	assign nxt_high = high_q;
	assign nxt_seq  = sq_q;

endmodule

// File: rtl/session_slot_table_core.sv
// Channel | handshake              | payload
// --------+------------------------+-----------------------------------------------
// in      | in_valid / in_stall    | cmd, slot_id
// out     | out_valid / out_stall  | status, slot_out, seq_out, highest_out,
//         |                        | used_count_out
// cfg     | cfg_valid / cfg_ready  | cfg_data (slot limit)
//
// The command wave steps through one cell of eight slots per clock, then through the
// chain-end holding register into the result register.
// Items run one at a time; in_stall is high from transfer until the result is registered.
// A finished result waits in the output register; the next item may be taken meanwhile
// and parks at the chain end until the output register is free.
// Asynchronous reset clears all used bits and sets every sequence number to 1 at once.
module session_slot_table_core #(
	parameter int NUM_SLOTS = sst_pkg::DEF_NUM_SLOTS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 cmd,
	input  logic [sst_pkg::SLOT_W-1:0] slot_id,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       status,
	output logic [sst_pkg::SLOT_W-1:0] slot_out,
	output logic [sst_pkg::SEQ_W-1:0]  seq_out,
	output logic [sst_pkg::SLOT_W-1:0] highest_out,
	output logic [sst_pkg::CNT_W-1:0]  used_count_out,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [sst_pkg::MAXS_W-1:0] cfg_data
);
	import sst_pkg::*;

	localparam int NUM_CELLS = (NUM_SLOTS + CELL_SLOTS - 1) / CELL_SLOTS;
	localparam int IDX_W     = $clog2(NUM_CELLS * CELL_SLOTS);
	localparam int LIM_W     = IDX_W + 1;
	localparam int CMP_W     = ((IDX_W > MAXS_W) ? IDX_W : MAXS_W) + 1;

	// control state
	logic              busy_q;
	logic [MAXS_W-1:0] maxs_q;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [IDX_W-1:0]  high_q, high_d;

	// links between cells; link 0 is the entry, the last one the chain end
	wave_t            lnk_wave [NUM_CELLS+1];
	logic [IDX_W-1:0] lnk_sid  [NUM_CELLS+1];
	logic [IDX_W-1:0] lnk_idx  [NUM_CELLS+1];
	logic [IDX_W-1:0] lnk_high [NUM_CELLS+1];
	logic [SEQ_W-1:0] lnk_seq  [NUM_CELLS+1];

	wave_t            ent_wave;
	logic             accept, sid_ok, load;
	logic [LIM_W-1:0] limit;

	// chain end holding stage
	wave_t            fin_wave_q;
	logic             fin_at_high_q;
	logic [IDX_W-1:0] fin_idx_q, fin_high_q;
	logic [SEQ_W-1:0] fin_seq_q;

	// result register
	logic              out_vld_q;
	logic              out_st_q, st_d;
	logic [SLOT_W-1:0] out_slot_q, slot_d;
	logic [SEQ_W-1:0]  out_seq_q, seq_d;
	logic [SLOT_W-1:0] out_high_q;
	logic [CNT_W-1:0]  out_cnt_q;

	assign accept    = in_valid && !busy_q;
	assign in_stall  = busy_q;
	assign cfg_ready = !busy_q;

	// grant limit is the slot limit register capped at the table size
	assign limit  = (CMP_W'(maxs_q) < CMP_W'(NUM_SLOTS)) ? LIM_W'(maxs_q) : LIM_W'(NUM_SLOTS);
	assign sid_ok = CMP_W'(slot_id) < CMP_W'(NUM_SLOTS);

	always_comb begin
		ent_wave        = '0;
		ent_wave.valid  = accept;
		ent_wave.cmd    = cmd_t'(cmd);
		ent_wave.get_ok = cnt_q < maxs_q;
		ent_wave.sid_ok = sid_ok;
	end

	assign lnk_wave[0] = ent_wave;
	assign lnk_sid[0]  = IDX_W'(slot_id);
	assign lnk_idx[0]  = '0;
	assign lnk_high[0] = '0;
	assign lnk_seq[0]  = '0;

	for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
		sst_cell #(
			.NUM_SLOTS(NUM_SLOTS),
			.CELL_IDX (c)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.prv_wave(lnk_wave[c]),
			.prv_sid (lnk_sid[c]),
			.prv_idx (lnk_idx[c]),
			.prv_high(lnk_high[c]),
			.prv_seq (lnk_seq[c]),
			.limit   (limit),
			.hmark   (high_q),
			.nxt_wave(lnk_wave[c+1]),
			.nxt_sid (lnk_sid[c+1]),
			.nxt_idx (lnk_idx[c+1]),
			.nxt_high(lnk_high[c+1]),
			.nxt_seq (lnk_seq[c+1])
		);
	end

	// result moves on once the output register is empty or being taken
	assign load = fin_wave_q.valid && (!out_vld_q || !out_stall);

	// counters and result fields for the item at the chain end
	always_comb begin
		cnt_d  = cnt_q;
		high_d = high_q;
		st_d   = ST_OK;
		slot_d = '0;
		seq_d  = '0;
		unique case (fin_wave_q.cmd)
			CMD_GET: begin
				if (fin_wave_q.found) begin
					cnt_d  = cnt_q + CNT_W'(1);
					high_d = (fin_idx_q > high_q) ? fin_idx_q : high_q;
					slot_d = SLOT_W'(fin_idx_q);
					seq_d  = fin_seq_q;
				end else begin
					st_d = ST_FULL;
				end
			end
			CMD_FREE: begin
				if (fin_wave_q.was_used && (cnt_q != '0)) begin
					cnt_d = cnt_q - CNT_W'(1);
				end
				// freeing the top slot walks the mark down to the next used one
				if (fin_at_high_q) begin
					high_d = fin_wave_q.high_hit ? fin_high_q : '0;
				end
			end
			CMD_BUMP: begin
				// sequence updated in the cell, counters untouched
			end
			CMD_CLEAR: begin
				cnt_d  = '0;
				high_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			maxs_q     <= MAXS_RST;
			cnt_q      <= '0;
			high_q     <= '0;
			fin_wave_q <= '0;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				maxs_q <= cfg_data;
			end

			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end

			if (lnk_wave[NUM_CELLS].valid) begin
				fin_wave_q <= lnk_wave[NUM_CELLS];
			end else if (load) begin
				fin_wave_q.valid <= 1'b0;
			end

			if (load) begin
				cnt_q     <= cnt_d;
				high_q    <= high_d;
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (lnk_wave[NUM_CELLS].valid) begin
			fin_at_high_q <= lnk_wave[NUM_CELLS].sid_ok && (lnk_sid[NUM_CELLS] == high_q);
			fin_idx_q     <= lnk_idx[NUM_CELLS];
			fin_high_q    <= lnk_high[NUM_CELLS];
			fin_seq_q     <= lnk_seq[NUM_CELLS];
		end
		if (load) begin
			out_st_q   <= st_d;
			out_slot_q <= slot_d;
			out_seq_q  <= seq_d;
			out_high_q <= SLOT_W'(high_d);
			out_cnt_q  <= cnt_d;
		end
	end

	assign out_valid      = out_vld_q;
	assign status         = out_st_q;
	assign slot_out       = out_slot_q;
	assign seq_out        = out_seq_q;
	assign highest_out    = out_high_q;
	assign used_count_out = out_cnt_q;

endmodule

// File: rtl/sst_checker.sv
module sst_checker #(
	parameter int NUM_SLOTS = sst_pkg::DEF_NUM_SLOTS
) (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic                       status,
	input logic [sst_pkg::SLOT_W-1:0] slot_out,
	input logic [sst_pkg::SEQ_W-1:0]  seq_out,
	input logic [sst_pkg::SLOT_W-1:0] highest_out,
	input logic [sst_pkg::CNT_W-1:0]  used_count_out
);
	import sst_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(slot_out) &&
		$stable(seq_out) && $stable(highest_out) && $stable(used_count_out))
		else $error("result changed while stalled");

	// one item at a time: a transfer closes the input
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open right after a transfer");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> used_count_out <= NUM_SLOTS)
		else $error("used count beyond table size");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_FULL) |-> (slot_out == '0) && (seq_out == '0))
		else $error("full result carries a slot");

	// empty table has its highest mark at zero
	a_empty_high: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (used_count_out == '0) |-> highest_out == '0)
		else $error("highest mark left on an empty table");

endmodule

bind session_slot_table_core sst_checker #(.NUM_SLOTS(NUM_SLOTS)) u_sst_checker (.*);

// File: test/tb_top.sv
`timescale 1ns / 100ps

// Slot table bench: one reply per request, so every accepted request pushes one
// predicted reply and every reply transfer pops the oldest one.
module tb_top;
	import sst_pkg::*;

	localparam int NUM          = DEF_NUM_SLOTS;
	localparam int LIMIT_CYCLES = 400_000;
	localparam int TAIL_CYCLES  = 24;      // longer than the chain latency
	localparam int PHASES       = 9;
	localparam int PHASE_ITEMS  = 128;

	// One reply as seen on the output ports
	typedef struct packed {
		logic              st;
		logic [SLOT_W-1:0] slot;
		logic [SEQ_W-1:0]  seq;
		logic [SLOT_W-1:0] high;
		logic [CNT_W-1:0]  cnt;
	} table_reply_t;

	// Directed script line: either a slot limit write or a request, the latter
	// optionally carrying a hand-written reply
	typedef struct packed {
		bit                is_cfg;
		logic [MAXS_W-1:0] lim;
		cmd_t              op;
		logic [SLOT_W-1:0] sid;
		bit                typed;
		table_reply_t      want;
	} script_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [1:0]          cmd;
	logic [SLOT_W-1:0]   slot_id;
	logic                out_valid;
	logic                out_stall;
	logic                status;
	logic [SLOT_W-1:0]   slot_out;
	logic [SEQ_W-1:0]    seq_out;
	logic [SLOT_W-1:0]   highest_out;
	logic [CNT_W-1:0]    used_count_out;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [MAXS_W-1:0]   cfg_data;

	// Local copy of the table
	bit                  busy_m [NUM];
	logic [SEQ_W-1:0]    seq_m  [NUM];
	int                  used_m;
	int                  high_m;
	int                  max_m;

	table_reply_t        pending_replies [$];
	script_row_t         script [$];

	int                  bad_replies;
	int                  cycles;
	int                  rx_hold;
	bit                  no_idle;
	int                  n_items, n_grant, n_full, n_free, n_bump, n_clear, peak_used, n_limits;

	session_slot_table_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.cmd            (cmd),
		.slot_id        (slot_id),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.slot_out       (slot_out),
		.seq_out        (seq_out),
		.highest_out    (highest_out),
		.used_count_out (used_count_out),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Table wipe: used by reset and by the clear command
	function automatic void wipe_table();
		for (int i = 0; i < NUM; i++) begin
			busy_m[i] = 1'b0;
			seq_m[i]  = SEQ_INIT;
		end
		used_m = 0;
		high_m = 0;
	endfunction

	// Applies one request to the local table and returns the reply it yields.
	// slot_id is six bits wide, so with 64 slots it always names a real slot.
	function automatic table_reply_t step_table(cmd_t op, logic [SLOT_W-1:0] sid);
		table_reply_t r;
		int lim;
		int pick;
		int i;
		r    = '0;
		pick = -1;
		n_items++;
		case (op)
			CMD_GET: begin
				lim = (max_m < NUM) ? max_m : NUM;
				// count check first: a limit of zero, or a full count, means full
				if (used_m < max_m) begin
					i = 0;
					while (pick < 0 && i < lim) begin
						if (!busy_m[i])
							pick = i;
						i++;
					end
				end
				if (pick >= 0) begin
					busy_m[pick] = 1'b1;
					used_m++;
					if (pick > high_m)
						high_m = pick;
					r.slot = pick[SLOT_W-1:0];
					r.seq  = seq_m[pick];
					n_grant++;
				end else begin
					r.st = ST_FULL;
					n_full++;
				end
			end
			CMD_FREE: begin
				if (busy_m[sid]) begin
					busy_m[sid] = 1'b0;
					if (used_m > 0)
						used_m--;
				end
				// freeing the top mark walks it down, even for an idle slot
				if (int'(sid) == high_m)
					while (high_m > 0 && !busy_m[high_m])
						high_m--;
				n_free++;
			end
			CMD_BUMP: begin
				seq_m[sid] = seq_m[sid] + SEQ_W'(1);   // wraps at 2^32
				n_bump++;
			end
			default: begin
				wipe_table();
				n_clear++;
			end
		endcase
		if (used_m > peak_used)
			peak_used = used_m;
		r.high = high_m[SLOT_W-1:0];
		r.cnt  = used_m[CNT_W-1:0];
		return r;
	endfunction

	// Random busy slot, or -1 on an empty table
	function automatic int any_busy_slot();
		int busy_list [$];
		for (int i = 0; i < NUM; i++)
			if (busy_m[i])
				busy_list.push_back(i);
		if (busy_list.size() == 0)
			return -1;
		return busy_list[$urandom_range(0, busy_list.size() - 1)];
	endfunction

	// ------------------------------------------------------------------
	// Script builders
	// ------------------------------------------------------------------

	function automatic void row_cfg(logic [MAXS_W-1:0] v);
		script_row_t s;
		s        = '0;
		s.is_cfg = 1'b1;
		s.lim    = v;
		script.push_back(s);
	endfunction

	// request checked against the predictor only
	function automatic void row_op(cmd_t op, logic [SLOT_W-1:0] sid);
		script_row_t s;
		s     = '0;
		s.op  = op;
		s.sid = sid;
		script.push_back(s);
	endfunction

	// request with the reply written out by hand
	function automatic void row_chk(cmd_t op, logic [SLOT_W-1:0] sid, logic st,
	                                logic [SLOT_W-1:0] slot, logic [SEQ_W-1:0] seq,
	                                logic [SLOT_W-1:0] high, logic [CNT_W-1:0] cnt);
		script_row_t s;
		s       = '0;
		s.op    = op;
		s.sid   = sid;
		s.typed = 1'b1;
		s.want  = '{st: st, slot: slot, seq: seq, high: high, cnt: cnt};
		script.push_back(s);
	endfunction

	// ------------------------------------------------------------------
	// Request side
	// ------------------------------------------------------------------

	// Sends one request. Valid stays high after the transfer so that a
	// back-to-back request never drops and re-raises it in one step.
	task automatic put_request(cmd_t op, logic [SLOT_W-1:0] sid, bit typed,
	                           table_reply_t want);
		int gap;
		table_reply_t got;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd      <= op;
		slot_id  <= sid;
		do @(posedge clk); while (in_stall);
		got = step_table(op, sid);
		pending_replies.push_back(typed ? want : got);
	endtask

	// slot limit write, only once every reply is home (one reply per request,
	// so an empty queue means the chain is empty too)
	task automatic set_slot_limit(logic [MAXS_W-1:0] v);
		in_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_m = int'(v);
		n_limits++;
	endtask

	// ------------------------------------------------------------------
	// Reply side: random stall before each transfer, checked on transfer
	// ------------------------------------------------------------------

	always @(posedge clk) begin
		table_reply_t got;
		table_reply_t want;
		got = '{st: status, slot: slot_out, seq: seq_out, high: highest_out,
		        cnt: used_count_out};
		if (arst_n && out_valid && !out_stall) begin
			if (pending_replies.size() == 0) begin
				bad_replies++;
				if (bad_replies <= 10)
					$display("[%0d] reply with nothing pending: st=%0d slot=%0d seq=%0d hi=%0d cnt=%0d",
					         cycles, got.st, got.slot, got.seq, got.high, got.cnt);
			end else begin
				want = pending_replies.pop_front();
				if (got.st !== want.st || got.slot !== want.slot || got.seq !== want.seq ||
				    got.high !== want.high || got.cnt !== want.cnt) begin
					bad_replies++;
					if (bad_replies <= 10)
						$display("[%0d] reply mismatch exp st=%0d slot=%0d seq=%0d hi=%0d cnt=%0d / got st=%0d slot=%0d seq=%0d hi=%0d cnt=%0d",
						         cycles, want.st, want.slot, want.seq, want.high, want.cnt,
						         got.st, got.slot, got.seq, got.high, got.cnt);
				end
			end
			rx_hold = no_idle ? 0 : $urandom_range(0, 8);
		end
		// hold-off counts down only while a reply is actually waiting
		out_stall <= (rx_hold > 0);
		if (out_valid && rx_hold > 0)
			rx_hold--;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycles,
			         pending_replies.size());
			$display("** session_slot_table_core: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		int phase_lim [PHASES];
		int phase_get [PHASES];
		int pct;
		int sel;
		int slot;
		cmd_t op;
		logic [SLOT_W-1:0] sid;

		phase_lim = '{64, 127, 1, 0, 65, 2, 63, 128, 128};   // 128: draw one
		phase_get = '{70, 80, 50, 60, 75, 50, 70, 40, 60};

		arst_n    = 1'b0;
		in_valid  = 1'b0;
		cmd       = CMD_GET;
		slot_id   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		out_stall = 1'b0;
		rx_hold   = 0;
		no_idle   = 1'b0;
		bad_replies = 0;
		cycles    = 0;
		n_items = 0; n_grant = 0; n_full = 0; n_free = 0; n_bump = 0; n_clear = 0;
		peak_used = 0; n_limits = 0;
		wipe_table();
		max_m = int'(MAXS_RST);

		// -- directed script; the first block runs on the reset limit of 64 --
		row_chk(CMD_GET,   6'd0,  ST_OK, 6'd0, 32'd1, 6'd0, 7'd1);
		row_chk(CMD_GET,   6'd63, ST_OK, 6'd1, 32'd1, 6'd1, 7'd2);  // slot_id ignored
		row_chk(CMD_BUMP,  6'd0,  ST_OK, 6'd0, 32'd0, 6'd1, 7'd2);
		row_chk(CMD_FREE,  6'd0,  ST_OK, 6'd0, 32'd0, 6'd1, 7'd1);  // below the mark
		row_chk(CMD_GET,   6'd0,  ST_OK, 6'd0, 32'd2, 6'd1, 7'd2);  // bumped sequence
		row_op (CMD_BUMP,  6'd63);
		row_chk(CMD_FREE,  6'd1,  ST_OK, 6'd0, 32'd0, 6'd0, 7'd1);  // mark walks down
		row_chk(CMD_FREE,  6'd5,  ST_OK, 6'd0, 32'd0, 6'd0, 7'd1);  // idle slot
		row_chk(CMD_FREE,  6'd0,  ST_OK, 6'd0, 32'd0, 6'd0, 7'd0);  // empty: mark 0
		row_chk(CMD_FREE,  6'd0,  ST_OK, 6'd0, 32'd0, 6'd0, 7'd0);  // idle slot at mark
		row_op (CMD_GET,   6'd42);
		row_chk(CMD_CLEAR, 6'd21, ST_OK, 6'd0, 32'd0, 6'd0, 7'd0);
		row_chk(CMD_GET,   6'd0,  ST_OK, 6'd0, 32'd1, 6'd0, 7'd1);  // sequence back to 1
		// limit of one slot
		row_cfg(7'd1);
		row_chk(CMD_GET,   6'd0,  ST_FULL, 6'd0, 32'd0, 6'd0, 7'd1);
		row_chk(CMD_FREE,  6'd0,  ST_OK,   6'd0, 32'd0, 6'd0, 7'd0);
		row_chk(CMD_GET,   6'd0,  ST_OK,   6'd0, 32'd1, 6'd0, 7'd1);
		row_chk(CMD_GET,   6'd63, ST_FULL, 6'd0, 32'd0, 6'd0, 7'd1);
		// zero limit: every get is full
		row_cfg(7'd0);
		row_chk(CMD_FREE,  6'd0,  ST_OK,   6'd0, 32'd0, 6'd0, 7'd0);
		row_chk(CMD_GET,   6'd0,  ST_FULL, 6'd0, 32'd0, 6'd0, 7'd0);
		// limit above the table size is capped
		row_cfg(7'd127);
		row_chk(CMD_GET,   6'd0,  ST_OK, 6'd0, 32'd1, 6'd0, 7'd1);
		row_op (CMD_BUMP,  6'd63);
		row_op (CMD_FREE,  6'd63);
		row_op (CMD_GET,   6'd0);
		row_op (CMD_FREE,  6'd0);
		row_chk(CMD_CLEAR, 6'd63, ST_OK, 6'd0, 32'd0, 6'd0, 7'd0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[k]) begin
			if (script[k].is_cfg)
				set_slot_limit(script[k].lim);
			else
				put_request(script[k].op, script[k].sid, script[k].typed, script[k].want);
		end

		// -- random phases: each a limit setting and a get/free balance --
		// Get-heavy phases fill the table so full replies and high grants
		// turn up; the lighter ones drain it again.
		for (int ph = 0; ph < PHASES; ph++) begin
			set_slot_limit(MAXS_W'(phase_lim[ph] > 127 ? $urandom_range(0, 127) :
			                                             phase_lim[ph]));
			pct     = phase_get[ph];
			no_idle = (ph % 3 == 2);   // a back-to-back stretch every third phase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				sel = $urandom_range(0, 99);
				sid = SLOT_W'($urandom_range(0, NUM - 1));
				if (sel == 99) begin
					op = CMD_CLEAR;
				end else if (sel < pct) begin
					op = CMD_GET;
				end else if ($urandom_range(0, 9) < 6) begin
					op  = CMD_FREE;
					sel = $urandom_range(0, 9);
					slot = any_busy_slot();
					if (sel == 6)
						sid = high_m[SLOT_W-1:0];
					else if (sel < 6 && slot >= 0)
						sid = slot[SLOT_W-1:0];
				end else begin
					op   = CMD_BUMP;
					slot = any_busy_slot();
					if ($urandom_range(0, 1) == 0 && slot >= 0)
						sid = slot[SLOT_W-1:0];
				end
				put_request(op, sid, 1'b0, '0);
			end
		end

		// -- drain --
		in_valid <= 1'b0;
		no_idle  = 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_replies.size() != 0)
			bad_replies++;

		$display("%0d requests over %0d slot limit settings: %0d grants, %0d full, %0d frees",
		         n_items, n_limits, n_grant, n_full, n_free);
		$display("%0d bumps, %0d table clears, peak occupancy %0d, %0d bad replies",
		         n_bump, n_clear, peak_used, bad_replies);
		if (bad_replies == 0)
			$display("** session_slot_table_core: PASSED **");
		else
			$display("** session_slot_table_core: FAILED **");
		$finish;
	end

endmodule
